FILE: src/ssv_pkg.sv
// ----------------------------------------------------------------------------
// ssv_pkg
// Shared types, constants and the byte-wide CRC-32 step for the sealed slot
// verifier.
// ----------------------------------------------------------------------------
package ssv_pkg;

  // Default block size that a sequence-end value must be a multiple of
  localparam int unsigned SEQ_BLOCK_SIZE_DEF = 64;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL  = 32'hFFFF_FFFF;

  // Seal offsets (stored CRC position) per slot kind
  localparam logic [5:0] SEAL_OFF_PAGE  = 6'd56;
  localparam logic [5:0] SEAL_OFF_STATE = 6'd24;
  localparam logic [5:0] SEAL_OFF_SHORT = 6'd8;

  // Page header field boundaries
  localparam logic [5:0] PAGE_VERSION_IDX = 6'd4;
  localparam logic [5:0] PAGE_RSVD_END    = 6'd8;
  localparam logic [5:0] PAGE_GEN_END     = 6'd16;
  localparam logic [5:0] PAGE_DEV_END     = 6'd24;

  // Slot kinds
  typedef enum logic [1:0] {
    KIND_PAGE    = 2'd0,
    KIND_SEQ_END = 2'd1,
    KIND_STATE   = 2'd2,
    KIND_UNUSED  = 2'd3
  } slot_kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAGE_MAGIC     = 2'd0,
    CFG_FORMAT_VERSION = 2'd1,
    CFG_COMMIT_WORD    = 2'd2,
    CFG_DEVICE_ID      = 2'd3
  } cfg_reg_t;

  // Configuration values seen by the slot core
  typedef struct packed {
    logic [31:0] page_magic;
    logic [7:0]  format_version;
    logic [31:0] commit_word;
    logic [63:0] device_id;
  } ssv_cfg_t;

  // One slot verdict
  typedef struct packed {
    logic        slot_valid;
    slot_kind_t  kind_seen;
    logic [63:0] first_value;
    logic [63:0] second_value;
    logic [63:0] third_value;
  } ssv_result_t;

  // Advance the CRC over one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

FILE: src/ssv_slot_core.sv
// ----------------------------------------------------------------------------
// ssv_slot_core
// Per-slot state: byte position, running CRC, tail window, decoded values
// and field checks. Produces a verdict at the slot's last byte.
// ----------------------------------------------------------------------------
module ssv_slot_core #(
  parameter int unsigned SEQUENCE_BLOCK_SIZE = ssv_pkg::SEQ_BLOCK_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat_en,
  input  logic [7:0]          data_byte,
  input  ssv_pkg::slot_kind_t slot_kind,
  input  ssv_pkg::ssv_cfg_t   cfg,
  output logic                done,
  output ssv_pkg::ssv_result_t result
);
  import ssv_pkg::*;

  // Remainder of the sequence-end value modulo the block size, one bit per step
  localparam int unsigned RemW = $clog2(SEQUENCE_BLOCK_SIZE) + 1;
  localparam logic [RemW-1:0] BlkSize = RemW'(SEQUENCE_BLOCK_SIZE);

  function automatic logic [RemW-1:0] rem_step(input logic [RemW-1:0] r, input logic [7:0] b);
    logic [RemW-1:0] t;
    t = r;
    for (int i = 0; i < 8; i++) begin
      t = (t << 1) | RemW'(b[7-i]);
      if (t >= BlkSize) begin
        t = t - BlkSize;
      end
    end
    return t;
  endfunction

  logic [5:0]      byte_index_r, byte_index_nxt;
  slot_kind_t      latched_kind_r, latched_kind_nxt;
  logic [31:0]     running_crc_r, running_crc_nxt;
  logic [63:0]     tail_window_r, tail_window_nxt;
  logic [63:0]     value_one_r, value_one_nxt;
  logic [63:0]     value_two_r, value_two_nxt;
  logic [63:0]     value_three_r, value_three_nxt;
  logic            fault_seen_r, fault_seen_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;

  logic [5:0]      idx;
  logic [5:0]      seal_off;
  logic            last;
  logic            sealed;
  logic [7:0]      magic_byte;
  logic [7:0]      dev_byte;

  assign idx = byte_index_r;

  // Expected header bytes, most significant first
  assign magic_byte = cfg.page_magic[{~idx[1:0], 3'b000} +: 8];
  assign dev_byte   = cfg.device_id[{~idx[2:0], 3'b000} +: 8];

  // Next slot state for one beat
  always_comb begin
    // start from a clean slot at the first byte
    if (idx == 6'd0) begin
      latched_kind_nxt = slot_kind;
      running_crc_nxt  = CRC_ALL;
      tail_window_nxt  = '0;
      value_one_nxt    = '0;
      value_two_nxt    = '0;
      value_three_nxt  = '0;
      fault_seen_nxt   = 1'b0;
      rem_nxt          = '0;
    end else begin
      latched_kind_nxt = latched_kind_r;
      running_crc_nxt  = running_crc_r;
      tail_window_nxt  = tail_window_r;
      value_one_nxt    = value_one_r;
      value_two_nxt    = value_two_r;
      value_three_nxt  = value_three_r;
      fault_seen_nxt   = fault_seen_r;
      rem_nxt          = rem_r;
    end

    unique case (latched_kind_nxt)
      KIND_PAGE:  seal_off = SEAL_OFF_PAGE;
      KIND_STATE: seal_off = SEAL_OFF_STATE;
      default:    seal_off = SEAL_OFF_SHORT;
    endcase

    // CRC over the protected bytes, window over the last eight
    if (idx < seal_off) begin
      running_crc_nxt = crc_byte(running_crc_nxt, data_byte);
    end
    tail_window_nxt = {tail_window_nxt[55:0], data_byte};

    // Field checks and value capture
    case (latched_kind_nxt)
      KIND_PAGE: begin
        if (idx < PAGE_VERSION_IDX) begin
          if (data_byte != magic_byte) fault_seen_nxt = 1'b1;
        end else if (idx == PAGE_VERSION_IDX) begin
          if (data_byte != cfg.format_version) fault_seen_nxt = 1'b1;
        end else if (idx < PAGE_RSVD_END) begin
          if (data_byte != 8'd0) fault_seen_nxt = 1'b1;
        end else if (idx < PAGE_GEN_END) begin
          value_one_nxt = {value_one_nxt[55:0], data_byte};
        end else if (idx < PAGE_DEV_END) begin
          if (data_byte != dev_byte) fault_seen_nxt = 1'b1;
        end else if (idx < SEAL_OFF_PAGE) begin
          if (data_byte != 8'd0) fault_seen_nxt = 1'b1;
        end
      end
      KIND_SEQ_END: begin
        if (idx < 6'd8) begin
          value_one_nxt = {value_one_nxt[55:0], data_byte};
          rem_nxt       = rem_step(rem_nxt, data_byte);
        end
      end
      KIND_STATE: begin
        if (idx < 6'd8) begin
          value_one_nxt = {value_one_nxt[55:0], data_byte};
        end else if (idx < 6'd16) begin
          value_two_nxt = {value_two_nxt[55:0], data_byte};
        end else if (idx < 6'd24) begin
          value_three_nxt = {value_three_nxt[55:0], data_byte};
        end
      end
      default: fault_seen_nxt = 1'b1;
    endcase

    last           = (idx == seal_off + 6'd7);
    byte_index_nxt = last ? 6'd0 : idx + 6'd1;

    // Seal: big-endian stored CRC, then commit word
    sealed = (tail_window_nxt[31:0] == cfg.commit_word) &&
             (tail_window_nxt[63:32] == ~running_crc_nxt);

    result.kind_seen    = latched_kind_nxt;
    result.first_value  = value_one_nxt;
    result.second_value = '0;
    result.third_value  = '0;
    case (latched_kind_nxt)
      KIND_PAGE: begin
        result.slot_valid = !fault_seen_nxt && (value_one_nxt != '0) && sealed;
      end
      KIND_SEQ_END: begin
        result.slot_valid = sealed && (value_one_nxt != '0) && (rem_nxt == '0);
      end
      KIND_STATE: begin
        result.slot_valid   = sealed && (value_one_nxt != '0);
        result.second_value = value_two_nxt;
        result.third_value  = value_three_nxt;
      end
      default: begin
        result.slot_valid  = 1'b0;
        result.first_value = '0;
      end
    endcase
  end

  assign done = beat_en && last;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= '0;
      latched_kind_r <= KIND_PAGE;
    end else if (beat_en) begin
      byte_index_r   <= byte_index_nxt;
      latched_kind_r <= latched_kind_nxt;
    end
  end

  // Slot payload; rebuilt at each slot's first byte
  always_ff @(posedge clk) begin
    if (beat_en) begin
      running_crc_r <= running_crc_nxt;
      tail_window_r <= tail_window_nxt;
      value_one_r   <= value_one_nxt;
      value_two_r   <= value_two_nxt;
      value_three_r <= value_three_nxt;
      fault_seen_r  <= fault_seen_nxt;
      rem_r         <= rem_nxt;
    end
  end

endmodule

FILE: src/sealed_slot_verifier.sv
// The result is registered: it appears on out_ in the cycle after the slot's last byte beat.
// Throughput: one byte per cycle unless stalled; the byte-wide CRC step and the field checks
// sit between the slot state registers and the result register.
// A waiting result stalls input only while out_tready is low.
// Reset (rst_n low, synchronous): slot position cleared, output empty,
// configuration registers zero.
// ----------------------------------------------------------------------------
// sealed_slot_verifier
// Checks sealed journal slots fed one byte per beat and reports validity
// with the decoded 64-bit values at each slot's last byte.
// ----------------------------------------------------------------------------
module sealed_slot_verifier #(
  parameter int unsigned SEQUENCE_BLOCK_SIZE = ssv_pkg::SEQ_BLOCK_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // byte input
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] data_byte
  input  logic [1:0]    in_tuser,   // [1:0] slot_kind
  // result output
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [191:0]  out_tdata,  // [63:0] first_value, [127:64] second_value,
                                    // [191:128] third_value
  output logic [2:0]    out_tuser,  // [0] slot_valid, [2:1] kind_seen
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  ssv_pkg::cfg_reg_t cfg_index,
  input  logic [63:0]   cfg_data
);
  import ssv_pkg::*;

  ssv_cfg_t    cfg_r;
  logic        out_tvalid_r;
  ssv_result_t out_r;
  ssv_result_t core_result;
  logic        core_done;
  logic        in_beat;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PAGE_MAGIC:     cfg_r.page_magic     <= cfg_data[31:0];
        CFG_FORMAT_VERSION: cfg_r.format_version <= cfg_data[7:0];
        CFG_COMMIT_WORD:    cfg_r.commit_word    <= cfg_data[31:0];
        CFG_DEVICE_ID:      cfg_r.device_id      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the result register is free or draining
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  ssv_slot_core #(
    .SEQUENCE_BLOCK_SIZE(SEQUENCE_BLOCK_SIZE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_en   (in_beat),
    .data_byte (in_tdata),
    .slot_kind (slot_kind_t'(in_tuser)),
    .cfg       (cfg_r),
    .done      (core_done),
    .result    (core_result)
  );

  // Result register: load on a slot's last byte, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (core_done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      out_r <= core_result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_r.third_value, out_r.second_value, out_r.first_value};
  assign out_tuser  = {out_r.kind_seen, out_r.slot_valid};

endmodule
